>>> sv/tppb_pkg.sv
// shared types and codes for the tape pulse-pair byte decoder
// no dependencies; used by tppb_decode and tape_pulse_pair_byte_decoder_core
package tppb_pkg;

    localparam int unsigned PulseWidth = 2;
    localparam int unsigned KindWidth  = 2;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned CountWidth = 16;
    localparam int unsigned IndexWidth = 4;

    localparam logic [PulseWidth-1:0] PULSE_SHORT  = 2'd0;
    localparam logic [PulseWidth-1:0] PULSE_MEDIUM = 2'd1;
    localparam logic [PulseWidth-1:0] PULSE_LONG   = 2'd2;
    localparam logic [PulseWidth-1:0] PULSE_BAD    = 2'd3;

    localparam logic [KindWidth-1:0] EV_BYTE = 2'd0;
    localparam logic [KindWidth-1:0] EV_END  = 2'd1;
    localparam logic [KindWidth-1:0] EV_ERR  = 2'd2;

    localparam logic [IndexWidth-1:0] REG_ALLOW_LEADING_SHORT = 4'd0;
    localparam logic [IndexWidth-1:0] REG_EXPECTED_BYTES      = 4'd1;

    localparam logic [CountWidth-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                  valid;
        logic [KindWidth-1:0]  event_kind;
        logic [ByteWidth-1:0]  data_byte;
        logic                  within_length;
        logic [ByteWidth-1:0]  block_checksum;
        logic [CountWidth-1:0] byte_count;
    } tppb_result_t;

endpackage

>>> sv/tape_pulse_pair_byte_decoder_core.sv
// top level: input register, decoder, result register and config registers
// depends on tppb_pkg and tppb_decode
//
//  channel   ports            carries
//  input     s_t*             one classified pulse per item
//  result    m_t*             data byte, end marker or error
//  config    cfg_*            register index and write data
//
//  one pulse per cycle sustained while results are not stalled; a pulse passes
//  through the input register, then is decoded into the result register
//  aresetn is synchronous: decoder restarts hunting, config returns to defaults
//  a stalled result holds the decoder; the input register still takes one item
//  cfg_ready is always high
module tape_pulse_pair_byte_decoder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,    // [1:0] pulse_class
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,    // [7:0] data_byte, [8] within_length,
                                                           // [16:9] block_checksum, [32:17] byte_count
    output logic [tppb_pkg::KindWidth-1:0]     m_tuser,    // [1:0] event_kind
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tppb_pkg::IndexWidth-1:0]    cfg_index,
    input  logic [tppb_pkg::CountWidth-1:0]    cfg_data
);

    logic                                in_valid_reg;
    logic [tppb_pkg::PulseWidth-1:0]     in_pulse_reg;
    logic                                out_valid_reg;
    tppb_pkg::tppb_result_t              out_reg;
    logic                                allow_short_reg;
    logic [tppb_pkg::CountWidth-1:0]     expected_reg;
    logic                                advance;
    tppb_pkg::tppb_result_t              res;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    tppb_decode u_decode (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .step                (advance),
        .pulse_class         (in_pulse_reg),
        .allow_leading_short (allow_short_reg),
        .expected_bytes      (expected_reg),
        .res                 (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_pulse_reg <= s_tdata[tppb_pkg::PulseWidth-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && res.valid) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_short_reg <= 1'b1;
            expected_reg    <= tppb_pkg::COUNT_MAX;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tppb_pkg::REG_ALLOW_LEADING_SHORT: allow_short_reg <= cfg_data[0];
                tppb_pkg::REG_EXPECTED_BYTES:      expected_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {7'd0, out_reg.byte_count, out_reg.block_checksum,
                       out_reg.within_length, out_reg.data_byte};

endmodule

>>> sv/tppb_decode.sv
// decoder state and next-state logic: sync hunt, bit pairs, parity, block totals
// depends on tppb_pkg
module tppb_decode (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [tppb_pkg::PulseWidth-1:0]     pulse_class,
    input  logic                                allow_leading_short,
    input  logic [tppb_pkg::CountWidth-1:0]     expected_bytes,
    output tppb_pkg::tppb_result_t              res
);

    typedef enum logic [1:0] {
        PH_HUNT       = 2'd0,
        PH_AFTER_LONG = 2'd1,
        PH_BITS       = 2'd2
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [tppb_pkg::PulseWidth-1:0]   first_pulse_reg, first_pulse_next;
    logic                              pair_half_reg, pair_half_next;
    logic [3:0]                        bit_index_reg, bit_index_next;
    logic [tppb_pkg::ByteWidth-1:0]    shift_byte_reg, shift_byte_next;
    logic                              parity_reg, parity_next;
    logic [tppb_pkg::ByteWidth-1:0]    checksum_reg, checksum_next;
    logic [tppb_pkg::CountWidth-1:0]   bytes_seen_reg, bytes_seen_next;
    logic                              no_byte_yet_reg, no_byte_yet_next;

    logic                              bit_ok;
    logic                              bit_val;
    logic                              parity_new;
    logic                              error_hit;
    logic                              restart_byte;
    logic                              restart_block;

    always_comb begin
        bit_ok  = 1'b0;
        bit_val = 1'b0;
        if (first_pulse_reg == tppb_pkg::PULSE_SHORT && pulse_class == tppb_pkg::PULSE_MEDIUM) begin
            bit_ok = 1'b1;
        end else if (first_pulse_reg == tppb_pkg::PULSE_MEDIUM
                     && pulse_class == tppb_pkg::PULSE_SHORT) begin
            bit_ok  = 1'b1;
            bit_val = 1'b1;
        end
        parity_new = parity_reg ^ bit_val;
    end

    always_comb begin
        phase_next       = phase_reg;
        first_pulse_next = first_pulse_reg;
        pair_half_next   = pair_half_reg;
        bit_index_next   = bit_index_reg;
        shift_byte_next  = shift_byte_reg;
        parity_next      = parity_reg;
        checksum_next    = checksum_reg;
        bytes_seen_next  = bytes_seen_reg;
        no_byte_yet_next = no_byte_yet_reg;
        error_hit        = 1'b0;
        restart_byte     = 1'b0;
        restart_block    = 1'b0;
        res              = '0;

        if (pulse_class == tppb_pkg::PULSE_BAD) begin
            error_hit = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_AFTER_LONG: begin
                    if (pulse_class == tppb_pkg::PULSE_MEDIUM) begin
                        phase_next = PH_BITS;
                    end else if (pulse_class == tppb_pkg::PULSE_SHORT) begin
                        res.valid          = 1'b1;
                        res.event_kind     = tppb_pkg::EV_END;
                        res.block_checksum = checksum_reg;
                        res.byte_count     = bytes_seen_reg;
                        restart_block      = 1'b1;
                    end else begin
                        error_hit = 1'b1;
                    end
                end
                PH_BITS: begin
                    if (!pair_half_reg) begin
                        first_pulse_next = pulse_class;
                        pair_half_next   = 1'b1;
                    end else if (!bit_ok) begin
                        error_hit = 1'b1;
                    end else if (!bit_index_reg[3]) begin
                        pair_half_next  = 1'b0;
                        parity_next     = parity_new;
                        shift_byte_next = shift_byte_reg
                                          | (tppb_pkg::ByteWidth'(bit_val) << bit_index_reg[2:0]);
                        bit_index_next  = bit_index_reg + 4'd1;
                    end else if (!parity_new) begin
                        error_hit = 1'b1;
                    end else begin
                        res.valid         = 1'b1;
                        res.event_kind    = tppb_pkg::EV_BYTE;
                        res.data_byte     = shift_byte_reg;
                        res.within_length = (bytes_seen_reg < expected_bytes);
                        checksum_next     = checksum_reg ^ shift_byte_reg;
                        if (bytes_seen_reg != tppb_pkg::COUNT_MAX) begin
                            bytes_seen_next = bytes_seen_reg + 1'b1;
                        end
                        no_byte_yet_next  = 1'b0;
                        restart_byte      = 1'b1;
                    end
                end
                default: begin
                    if (pulse_class == tppb_pkg::PULSE_LONG) begin
                        phase_next = PH_AFTER_LONG;
                    end else if (!(pulse_class == tppb_pkg::PULSE_SHORT
                                   && allow_leading_short && no_byte_yet_reg)) begin
                        error_hit = 1'b1;
                    end
                end
            endcase
        end

        if (error_hit) begin
            res.valid      = 1'b1;
            res.event_kind = tppb_pkg::EV_ERR;
            restart_block  = 1'b1;
        end

        if (restart_byte || restart_block) begin
            phase_next       = PH_HUNT;
            first_pulse_next = '0;
            pair_half_next   = 1'b0;
            bit_index_next   = '0;
            shift_byte_next  = '0;
            parity_next      = 1'b0;
        end
        if (restart_block) begin
            checksum_next    = '0;
            bytes_seen_next  = '0;
            no_byte_yet_next = 1'b1;
        end

        if (!step) begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            first_pulse_reg <= '0;
            pair_half_reg   <= 1'b0;
            bit_index_reg   <= '0;
            shift_byte_reg  <= '0;
            parity_reg      <= 1'b0;
            checksum_reg    <= '0;
            bytes_seen_reg  <= '0;
            no_byte_yet_reg <= 1'b1;
        end else if (step) begin
            phase_reg       <= phase_next;
            first_pulse_reg <= first_pulse_next;
            pair_half_reg   <= pair_half_next;
            bit_index_reg   <= bit_index_next;
            shift_byte_reg  <= shift_byte_next;
            parity_reg      <= parity_next;
            checksum_reg    <= checksum_next;
            bytes_seen_reg  <= bytes_seen_next;
            no_byte_yet_reg <= no_byte_yet_next;
        end
    end

endmodule
